@@ hw/rtl/text_frame_deframer_top_defines.svh @@
// Assertion macros for the text frame deframer.
// Included by text_frame_deframer_top.sv; expects aclk and aresetn in scope.
`ifndef TEXT_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define TEXT_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tfd_pkg.sv @@
// Shared types, codes and character helpers for the text frame deframer.
// No dependencies; used by tfd_len_parse and text_frame_deframer_top.
package tfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 32;
    localparam int LEN_W      = 16;
    localparam int HDR_BYTES  = 8;
    localparam int LEN_CHARS  = 4;
    localparam int STORE_W    = (HDR_BYTES - 1) * BYTE_W;
    localparam int HCNT_W     = 3;
    localparam int OUT_DATA_W = 56;

    // Input request kind
    localparam logic IN_BYTE    = 1'b0;
    localparam logic IN_DISCARD = 1'b1;

    // Result kind
    typedef enum logic [1:0] {
        OK_PAYLOAD = 2'd0,
        OK_EMPTY   = 2'd1,
        OK_REJECT  = 2'd2
    } out_kind_t;

    // Length field parse status
    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] len;
    } len_parse_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) ||
               (c == 8'h85) || (c == 8'hA0);
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if ((c >= "0") && (c <= "9")) begin
            r = {1'b1, 4'(c - "0")};
        end else if ((c >= "a") && (c <= "f")) begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if ((c >= "A") && (c <= "F")) begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/tfd_len_parse.sv @@
// Combinational parser for the four-character ASCII hex length field.
// Depends on tfd_pkg (character helpers, len_parse_t).
module tfd_len_parse (
    input  logic [tfd_pkg::LEN_CHARS-1:0][tfd_pkg::BYTE_W-1:0] chars, // [0] first received
    output tfd_pkg::len_parse_t                                 result
);

    logic [tfd_pkg::LEN_CHARS-1:0] ws;
    logic                          all_ws;
    logic [1:0]                    s_idx;
    logic [1:0]                    e_idx;
    logic [2:0]                    e3;
    logic [2:0]                    pos;
    logic                          neg;
    logic                          pfx;
    logic                          bad;
    logic                          empty;
    logic [4:0]                    hv;
    logic [tfd_pkg::LEN_W-1:0]     val;

    always_comb begin
        for (int k = 0; k < tfd_pkg::LEN_CHARS; k++) begin
            ws[2'(k)] = tfd_pkg::is_ws(chars[2'(k)]);
        end
        all_ws = &ws;

        // first and last non-blank character
        priority if (!ws[0]) s_idx = 2'd0;
        else if (!ws[1])     s_idx = 2'd1;
        else if (!ws[2])     s_idx = 2'd2;
        else                 s_idx = 2'd3;
        priority if (!ws[3]) e_idx = 2'd3;
        else if (!ws[2])     e_idx = 2'd2;
        else if (!ws[1])     e_idx = 2'd1;
        else                 e_idx = 2'd0;
        e3 = {1'b0, e_idx};

        // optional sign
        pos = {1'b0, s_idx};
        neg = 1'b0;
        if (chars[s_idx] == "+") begin
            pos = pos + 3'd1;
        end else if (chars[s_idx] == "-") begin
            neg = 1'b1;
            pos = pos + 3'd1;
        end

        // optional 0x / 0X prefix
        pfx = 1'b0;
        for (int p = 0; p < tfd_pkg::LEN_CHARS - 1; p++) begin
            if ((pos == 3'(p)) && (e3 >= 3'(p + 1)) && (chars[2'(p)] == "0") &&
                ((chars[2'(p + 1)] == "x") || (chars[2'(p + 1)] == "X"))) begin
                pfx = 1'b1;
            end
        end
        if (pfx) begin
            pos = pos + 3'd2;
        end
        empty = pos > e3;

        // hex digits from pos through e_idx
        bad = 1'b0;
        val = '0;
        hv  = '0;
        for (int k = 0; k < tfd_pkg::LEN_CHARS; k++) begin
            if ((3'(k) >= pos) && (3'(k) <= e3)) begin
                hv = tfd_pkg::hex_val(chars[2'(k)]);
                if (!hv[4]) begin
                    bad = 1'b1;
                end
                val = {val[tfd_pkg::LEN_W-5:0], hv[3:0]};
            end
        end

        result.ok  = !all_ws && !empty && !bad && !(neg && (val != '0));
        result.len = val;
    end

endmodule

@@ hw/rtl/text_frame_deframer_top.sv @@
// Text frame deframer: top level with input stage, header/payload tracking
// and output register. Depends on tfd_pkg, tfd_len_parse and the defines header.
//
// Usage:
//   Slave channel s_*: one request per byte. s_tuser[0] = 1 discards any
//   partial frame (s_tdata ignored); otherwise s_tdata is a stream byte.
//   A frame is 4 type bytes, 4 ASCII hex length characters, then payload.
//   Master channel m_*: one result per payload byte (kind payload, tlast on
//   the final byte), one "empty" result for a zero-length frame (tlast set),
//   or one "reject" result for an unparsable length field.
//   A request passes through the input register, then the result register.
//   The input stage takes one byte per cycle unless m_tready stalls a held
//   result; the frame state is updated between the two registers.
//   Header bytes, discards and the header that starts a payload give no result.
//   Reset (aresetn low, synchronous) empties both stages and returns to
//   header hunting with no partial frame.
//   Stall: while m_tready is low with a result held, the input stage holds
//   one more request; s_tready drops only when both stages are full.
module text_frame_deframer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tfd_pkg::BYTE_W-1:0]        s_tdata,  // in_byte
    input  logic [0:0]                        s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tfd_pkg::OUT_DATA_W-1:0]    m_tdata,  // msg_type, msg_length, payload_byte
    output logic [1:0]                        m_tuser,  // out_kind
    output logic                              m_tlast   // last_of_message
);

`include "text_frame_deframer_top_defines.svh"

    // input stage
    logic                          in_valid_reg;
    logic                          in_kind_reg;
    logic [tfd_pkg::BYTE_W-1:0]    in_byte_reg;

    // frame state
    logic [tfd_pkg::STORE_W-1:0]   header_store_reg, header_store_next;
    logic [tfd_pkg::HCNT_W-1:0]    header_count_reg, header_count_next;
    logic                          in_payload_reg, in_payload_next;
    logic [tfd_pkg::TYPE_W-1:0]    frame_type_reg, frame_type_next;
    logic [tfd_pkg::LEN_W-1:0]     frame_length_reg, frame_length_next;
    logic [tfd_pkg::LEN_W-1:0]     received_count_reg, received_count_next;

    // output register
    logic                          out_valid_reg;
    tfd_pkg::out_kind_t            out_kind_reg;
    logic [tfd_pkg::TYPE_W-1:0]    out_type_reg;
    logic [tfd_pkg::LEN_W-1:0]     out_length_reg;
    logic [tfd_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;

    // result of the current request
    logic                          res_valid;
    tfd_pkg::out_kind_t            res_kind;
    logic [tfd_pkg::TYPE_W-1:0]    res_type;
    logic [tfd_pkg::LEN_W-1:0]     res_length;
    logic [tfd_pkg::BYTE_W-1:0]    res_byte;
    logic                          res_last;

    logic                          out_free;
    logic                          proc;
    logic [tfd_pkg::LEN_W-1:0]     count_inc;
    logic [tfd_pkg::TYPE_W-1:0]    hdr_type;
    logic [tfd_pkg::LEN_CHARS-1:0][tfd_pkg::BYTE_W-1:0] len_chars;
    tfd_pkg::len_parse_t           parse;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    // header fields of the completing header
    assign hdr_type     = header_store_reg[tfd_pkg::STORE_W-1 -: tfd_pkg::TYPE_W];
    assign len_chars[0] = header_store_reg[23:16];
    assign len_chars[1] = header_store_reg[15:8];
    assign len_chars[2] = header_store_reg[7:0];
    assign len_chars[3] = in_byte_reg;

    tfd_len_parse u_len_parse (
        .chars  (len_chars),
        .result (parse)
    );

    assign count_inc = received_count_reg + tfd_pkg::LEN_W'(1);

    // next state and result
    always_comb begin
        header_store_next   = header_store_reg;
        header_count_next   = header_count_reg;
        in_payload_next     = in_payload_reg;
        frame_type_next     = frame_type_reg;
        frame_length_next   = frame_length_reg;
        received_count_next = received_count_reg;
        res_valid  = 1'b0;
        res_kind   = tfd_pkg::OK_PAYLOAD;
        res_type   = frame_type_reg;
        res_length = frame_length_reg;
        res_byte   = in_byte_reg;
        res_last   = 1'b0;

        if (in_kind_reg == tfd_pkg::IN_DISCARD) begin
            header_count_next   = '0;
            in_payload_next     = 1'b0;
            received_count_next = '0;
        end else if (in_payload_reg) begin
            res_valid = 1'b1;
            res_last  = (count_inc == frame_length_reg);
            if (res_last) begin
                in_payload_next     = 1'b0;
                received_count_next = '0;
            end else begin
                received_count_next = count_inc;
            end
        end else if (header_count_reg != tfd_pkg::HCNT_W'(tfd_pkg::HDR_BYTES - 1)) begin
            header_store_next = {header_store_reg[tfd_pkg::STORE_W-tfd_pkg::BYTE_W-1:0],
                                 in_byte_reg};
            header_count_next = header_count_reg + tfd_pkg::HCNT_W'(1);
        end else begin
            header_count_next = '0;
            header_store_next = '0;
            res_type   = hdr_type;
            res_length = '0;
            res_byte   = '0;
            if (!parse.ok) begin
                res_valid = 1'b1;
                res_kind  = tfd_pkg::OK_REJECT;
            end else if (parse.len == '0) begin
                res_valid = 1'b1;
                res_kind  = tfd_pkg::OK_EMPTY;
                res_last  = 1'b1;
            end else begin
                frame_type_next     = hdr_type;
                frame_length_next   = parse.len;
                received_count_next = '0;
                in_payload_next     = 1'b1;
            end
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg   <= '0;
            in_payload_reg     <= 1'b0;
            received_count_reg <= '0;
        end else if (proc) begin
            header_count_reg   <= header_count_next;
            in_payload_reg     <= in_payload_next;
            received_count_reg <= received_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            header_store_reg <= header_store_next;
            frame_type_reg   <= frame_type_next;
            frame_length_reg <= frame_length_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_valid && out_free) begin
            out_kind_reg   <= res_kind;
            out_type_reg   <= res_type;
            out_length_reg <= res_length;
            out_byte_reg   <= res_byte;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_byte_reg, out_length_reg, out_type_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // checks
    `TFD_ASSERT_NOW(a_payload_no_header, in_payload_reg, header_count_reg == '0,
        "header count nonzero during payload")
    `TFD_ASSERT_NOW(a_count_below_len, in_payload_reg,
        received_count_reg < frame_length_reg, "payload count reached frame length")
    `TFD_ASSERT_NOW(a_reject_fields, out_valid_reg && (out_kind_reg == tfd_pkg::OK_REJECT),
        !out_last_reg && (out_length_reg == '0), "reject result carries length or last")
    `TFD_ASSERT_NEXT(a_last_ends_payload,
        proc && in_payload_reg && (in_kind_reg == tfd_pkg::IN_BYTE) && res_last,
        !in_payload_reg, "payload state kept after last byte")

endmodule
